// ===== sv/mps_pkg.sv =====
// shared types, constants and helpers for the max pooling stream block
package mps_pkg;

  localparam int DATA_W       = 16;
  localparam int WS_W         = 5;
  localparam int MS_W         = 11;
  localparam int MAX_MAP_SIZE = 1024;
  localparam int WS_MAX       = 16;
  localparam int CIW_W        = $clog2(WS_MAX);
  localparam int WC_W         = $clog2(MAX_MAP_SIZE);
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = MS_W;
  localparam int DIV_STEPS    = MS_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAP_SIZE    = CFG_IDX_W'(1);

  localparam logic [WS_W-1:0]  WS_RESET      = WS_W'(2);
  localparam logic [MS_W-1:0]  MS_RESET      = MS_W'(32);
  localparam logic [CIW_W-1:0] WS_M1_RESET   = CIW_W'(2 - 1);
  localparam logic [WC_W-1:0]  NWIN_M1_RESET = WC_W'(32 / 2 - 1);

  typedef logic signed [DATA_W-1:0] pix_t;

  typedef enum logic [1:0] {
    CFG_READY,
    CFG_LOAD,
    CFG_DIV
  } cfg_state_t;

  typedef struct packed {
    logic             busy;
    logic             clear;
    logic             err;
    logic [CIW_W-1:0] ws_m1;
    logic [WC_W-1:0]  nwin_m1;
  } mps_cfg_t;

  typedef struct packed {
    pix_t            px;
    logic [WC_W-1:0] wcol;
    logic            first_col;
    logic            last_col;
    logic            first_row;
    logic            emit;
    logic            plane_last;
    logic            err;
  } mps_cmd_t;

  function automatic pix_t smax(pix_t a, pix_t b);
    return (a >= b) ? a : b;
  endfunction

endpackage

// ===== sv/mps_cfg.sv =====
// configuration registers with iterative divider for window count and check
module mps_cfg import mps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output mps_cfg_t              cfg
);

  cfg_state_t state_r, state_nxt;
  logic [WS_W-1:0]      ws_r;
  logic [MS_W-1:0]      ms_r;
  logic [MS_W-1:0]      dvd_r, dvd_nxt;
  logic [WS_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 err_r;
  logic [CIW_W-1:0]     ws_m1_r;
  logic [WC_W-1:0]      nwin_m1_r;
  logic                 busy, load_en, div_en, div_last;
  logic [WS_W:0]        sh;
  logic                 ge;
  logic                 range_err;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CFG_READY: if (cfg_wr_en) state_nxt = CFG_LOAD;
      CFG_LOAD:  state_nxt = CFG_DIV;
      CFG_DIV:   if (cnt_r == DIV_CNT_W'(1)) state_nxt = CFG_READY;
      default:   state_nxt = CFG_READY;
    endcase
    if (cfg_wr_en) state_nxt = CFG_LOAD;
  end

  always_comb begin
    busy    = 1'b1;
    load_en = 1'b0;
    div_en  = 1'b0;
    unique case (state_r)
      CFG_READY: busy = 1'b0;
      CFG_LOAD:  load_en = 1'b1;
      CFG_DIV:   div_en = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  // one quotient bit per cycle
  always_comb begin
    sh       = {rem_r, dvd_r[MS_W-1]};
    ge       = sh >= {1'b0, ws_r};
    rem_nxt  = ge ? WS_W'(sh - {1'b0, ws_r}) : sh[WS_W-1:0];
    dvd_nxt  = {dvd_r[MS_W-2:0], ge};
    div_last = div_en && (cnt_r == DIV_CNT_W'(1));
    range_err = (ws_r == '0) || (ws_r > WS_W'(WS_MAX)) ||
                (ms_r == '0) || (ms_r > MS_W'(MAX_MAP_SIZE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CFG_READY;
      ws_r      <= WS_RESET;
      ms_r      <= MS_RESET;
      err_r     <= 1'b0;
      ws_m1_r   <= WS_M1_RESET;
      nwin_m1_r <= NWIN_M1_RESET;
      cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en && cfg_index == REG_WINDOW_SIZE) ws_r <= cfg_wdata[WS_W-1:0];
      if (cfg_wr_en && cfg_index == REG_MAP_SIZE)    ms_r <= cfg_wdata[MS_W-1:0];
      if (load_en) cnt_r <= DIV_CNT_W'(DIV_STEPS);
      else if (div_en) cnt_r <= cnt_r - DIV_CNT_W'(1);
      if (div_last) begin
        err_r     <= range_err || (rem_nxt != '0);
        ws_m1_r   <= CIW_W'(ws_r - WS_W'(1));
        nwin_m1_r <= WC_W'(dvd_nxt - MS_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      dvd_r <= ms_r;
      rem_r <= '0;
    end else if (div_en) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign cfg.busy    = busy;
  assign cfg.clear   = cfg_wr_en;
  assign cfg.err     = err_r;
  assign cfg.ws_m1   = ws_m1_r;
  assign cfg.nwin_m1 = nwin_m1_r;

endmodule

// ===== sv/mps_front.sv =====
// front end: raster position counters and per-pixel classification
module mps_front import mps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mps_cfg_t cfg,
  input  logic     in_valid,
  input  pix_t     in_pixel_value,
  input  logic     fifo_full,
  output logic     in_stall,
  output logic     push,
  output mps_cmd_t cmd
);

  logic [CIW_W-1:0] cic_r, cic_nxt;
  logic [WC_W-1:0]  wcol_r, wcol_nxt;
  logic [CIW_W-1:0] riw_r, riw_nxt;
  logic [WC_W-1:0]  wrow_r, wrow_nxt;
  logic last_col, last_wc, last_row, last_wr;

  assign in_stall = cfg.busy || cfg.clear || fifo_full;
  assign push     = in_valid && !in_stall;

  always_comb begin
    last_col = cic_r == cfg.ws_m1;
    last_wc  = wcol_r == cfg.nwin_m1;
    last_row = riw_r == cfg.ws_m1;
    last_wr  = wrow_r == cfg.nwin_m1;

    cmd.px         = in_pixel_value;
    cmd.wcol       = wcol_r;
    cmd.first_col  = cic_r == '0;
    cmd.last_col   = last_col;
    cmd.first_row  = riw_r == '0;
    cmd.emit       = last_col && last_row;
    cmd.plane_last = last_wc && last_wr;
    cmd.err        = cfg.err;

    cic_nxt  = cic_r + CIW_W'(1);
    wcol_nxt = wcol_r;
    riw_nxt  = riw_r;
    wrow_nxt = wrow_r;
    if (last_col) begin
      cic_nxt  = '0;
      wcol_nxt = wcol_r + WC_W'(1);
      if (last_wc) begin
        wcol_nxt = '0;
        riw_nxt  = riw_r + CIW_W'(1);
        if (last_row) begin
          riw_nxt  = '0;
          wrow_nxt = last_wr ? '0 : wrow_r + WC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.clear) begin
      cic_r  <= '0;
      wcol_r <= '0;
      riw_r  <= '0;
      wrow_r <= '0;
    end else if (push && !cfg.err) begin
      cic_r  <= cic_nxt;
      wcol_r <= wcol_nxt;
      riw_r  <= riw_nxt;
      wrow_r <= wrow_nxt;
    end
  end

endmodule

// ===== sv/mps_fifo.sv =====
// small command queue between front and back end
module mps_fifo import mps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  mps_cmd_t din,
  input  logic     pop,
  output mps_cmd_t dout,
  output logic     full,
  output logic     not_empty
);

  mps_cmd_t              mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == FIFO_CNT_W'(FIFO_DEPTH);
  assign not_empty = cnt_r != '0;
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - FIFO_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// ===== sv/mps_back.sv =====
// back end: running maximum, row buffer of partial maxima, output register
module mps_back import mps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_vld,
  input  mps_cmd_t cmd,
  output logic     cmd_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output pix_t     out_pooled_value,
  output logic     out_plane_last,
  output logic     out_config_error
);

  pix_t     row_mem_r [MAX_MAP_SIZE];
  pix_t     rd_r;
  pix_t     rm_r, rm_nxt;
  logic     a_vld_r;
  mps_cmd_t a_cmd_r;
  logic     out_vld_r, out_vld_nxt;
  pix_t     pooled_r;
  logic     plane_last_r, err_r;
  logic     out_free, a_emit, a_adv, a_load;
  pix_t     merged;

  always_comb begin
    out_free = !out_vld_r || !out_stall;
    a_emit   = a_cmd_r.emit || a_cmd_r.err;
    a_adv    = a_vld_r && (!a_emit || out_free);
    a_load   = !a_vld_r || a_adv;
    cmd_pop  = cmd_vld && a_load;
    rm_nxt   = cmd.first_col ? cmd.px : smax(rm_r, cmd.px);
    merged   = a_cmd_r.first_row ? rm_r : smax(rd_r, rm_r);
    out_vld_nxt = out_vld_r;
    if (a_adv && a_emit) out_vld_nxt = 1'b1;
    else if (!out_stall) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      rm_r      <= '0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (a_load) a_vld_r <= cmd_vld;
      if (cmd_pop && !cmd.err) rm_r <= rm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      a_cmd_r <= cmd;
      rd_r    <= row_mem_r[cmd.wcol];
    end
    if (a_adv && a_cmd_r.last_col && !a_cmd_r.err) row_mem_r[a_cmd_r.wcol] <= merged;
    if (a_adv && a_emit) begin
      pooled_r     <= a_cmd_r.err ? pix_t'(0) : merged;
      plane_last_r <= a_cmd_r.plane_last && !a_cmd_r.err;
      err_r        <= a_cmd_r.err;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_pooled_value = pooled_r;
  assign out_plane_last   = plane_last_r;
  assign out_config_error = err_r;

endmodule

// ===== sv/max_pool_2d_stream.sv =====
// top level of the non-overlapping 2d max pooling stream block
//
// pixels of square planes enter in raster order on the in_ channel, one beat
// per pixel, planes back to back; one beat leaves on the out_ channel for each
// completed window, carrying its maximum and a flag on the last window of a plane
// both channels move a beat when valid is high and stall is low
// throughput: one pixel per cycle unless the output stalls or the divider runs
// the pixel closing a window passes the command queue, stage and output registers
// a four-entry command queue and the output register absorb short output stalls;
// in_stall rises once the queue fills
// a write on the cfg_ port restarts the plane at its top-left corner and holds
// in_stall high while the bit-serial divider derives the window count per row
// and checks that map_size is a multiple of window_size
// with an unusable configuration every pixel gives one beat with config_error set
// after reset window_size is 2 and map_size is 32, ready at once; the row buffer
// needs no clearing pass
module max_pool_2d_stream import mps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pix_t                  in_pixel_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pix_t                  out_pooled_value,
  output logic                  out_plane_last,
  output logic                  out_config_error,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  mps_cfg_t cfg;
  mps_cmd_t f_cmd, q_cmd;
  logic     push, pop, fifo_full, fifo_not_empty;

  mps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_pixel_value (in_pixel_value),
    .fifo_full      (fifo_full),
    .in_stall       (in_stall),
    .push           (push),
    .cmd            (f_cmd)
  );

  mps_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (f_cmd),
    .pop       (pop),
    .dout      (q_cmd),
    .full      (fifo_full),
    .not_empty (fifo_not_empty)
  );

  mps_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_vld          (fifo_not_empty),
    .cmd              (q_cmd),
    .cmd_pop          (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pooled_value (out_pooled_value),
    .out_plane_last   (out_plane_last),
    .out_config_error (out_config_error)
  );

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.busy |-> in_stall) else $error("pixel accepted during configuration check");

  a_cfg_write_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> in_stall) else $error("no stall after configuration write");

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_config_error |-> out_pooled_value == pix_t'(0) && !out_plane_last)
    else $error("error beat carries data");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_full || pop) else $error("command queue overflow");
`endif

endmodule

// ===== tb/max_pool_2d_stream_tb.sv =====
// testbench for max_pool_2d_stream: directed table, then random planes checked by a predictor
module max_pool_2d_stream_tb;
  import mps_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 80;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int RANDOM_ITEMS  = 1350;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_MAP_SIZE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

  typedef struct packed {
    pix_t value;
    logic last;
    logic err;
  } pool_result_t;

  typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    pix_t                  px;
    logic                  typed;
    pool_result_t          want;
  } dir_row_t;

  localparam pool_result_t NO_RES  = '0;
  localparam pool_result_t ERR_RES = '{value: '0, last: 1'b0, err: 1'b1};
  localparam int DIR_ROWS = 34;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  pix_t                  in_pixel_value;
  logic                  out_valid;
  logic                  out_stall;
  pix_t                  out_pooled_value;
  logic                  out_plane_last;
  logic                  out_config_error;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  max_pool_2d_stream u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_value   (in_pixel_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pooled_value (out_pooled_value),
    .out_plane_last   (out_plane_last),
    .out_config_error (out_config_error),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh7fff, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh8000, 1'b0, NO_RES},
    '{ROW_CFG,   REG_WINDOW_SIZE, 11'd1, '0, 1'b0, NO_RES},
    '{ROW_CFG,   REG_MAP_SIZE,    11'd1, '0, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh7fff, 1'b1, '{16'sh7fff, 1'b1, 1'b0}},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh8000, 1'b1, '{16'sh8000, 1'b1, 1'b0}},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'shffff, 1'b1, '{16'shffff, 1'b1, 1'b0}},
    '{ROW_CFG,   REG_MAP_SIZE,    11'd2, '0, 1'b0, NO_RES},
    '{ROW_CFG,   REG_WINDOW_SIZE, 11'd2, '0, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh0005, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'shfffd, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh0005, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh0005, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh8000, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh8000, 1'b0, NO_RES},
    '{ROW_CFG,   REG_UNUSED_HI,   11'h7ff, '0, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh8000, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh8000, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh8000, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh8000, 1'b1, '{16'sh8000, 1'b1, 1'b0}},
    '{ROW_CFG,   REG_WINDOW_SIZE, 11'd3, '0, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh04d2, 1'b1, ERR_RES},
    '{ROW_CFG,   REG_WINDOW_SIZE, 11'd0, '0, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh0000, 1'b1, ERR_RES},
    '{ROW_CFG,   REG_WINDOW_SIZE, 11'd17, '0, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh7fff, 1'b1, ERR_RES},
    '{ROW_CFG,   REG_WINDOW_SIZE, 11'h7e1, '0, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh002a, 1'b0, NO_RES},
    '{ROW_CFG,   REG_MAP_SIZE,    11'd0, '0, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh0001, 1'b1, ERR_RES},
    '{ROW_CFG,   REG_MAP_SIZE,    11'd1025, '0, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh8000, 1'b1, ERR_RES},
    '{ROW_CFG,   REG_MAP_SIZE,    11'h7ff, '0, 1'b0, NO_RES},
    '{ROW_PIXEL, REG_WINDOW_SIZE, '0, 16'sh7fff, 1'b1, ERR_RES}
  };

  // predictor state
  logic [WS_W-1:0] pool_ws;
  logic [MS_W-1:0] pool_ms;
  pix_t            col_max [MAX_MAP_SIZE];
  pix_t            run_max;
  int              col_in_win;
  int              win_col;
  int              row_in_win;
  int              win_row;

  pool_result_t pooled_q [$];
  pool_result_t got_want;
  int           mismatch_count;
  int           burst_left;
  int           random_items;
  bit           hold_req;

  function automatic void clear_position();
    run_max    = '0;
    col_in_win = 0;
    win_col    = 0;
    row_in_win = 0;
    win_row    = 0;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_WINDOW_SIZE) begin
      pool_ws = data[WS_W-1:0];
    end else if (idx == REG_MAP_SIZE) begin
      pool_ms = data[MS_W-1:0];
    end
    clear_position();
  endfunction

  function automatic void predict_pool(input pix_t px, output bit emits, output pool_result_t res);
    int   ws;
    int   ms;
    int   nwin;
    pix_t merged;
    ws    = pool_ws;
    ms    = pool_ms;
    emits = 1'b0;
    res   = '0;
    if (ws == 0 || ws > WS_MAX || ms == 0 || ms > MAX_MAP_SIZE || (ms % ws) != 0) begin
      emits   = 1'b1;
      res.err = 1'b1;
    end else begin
      nwin = ms / ws;
      if (col_in_win >= ws || row_in_win >= ws || win_col >= nwin || win_row >= nwin) begin
        clear_position();
      end
      if (col_in_win == 0 || px > run_max) begin
        run_max = px;
      end
      if (col_in_win == ws - 1) begin
        if (row_in_win == 0 || run_max > col_max[win_col]) begin
          merged = run_max;
        end else begin
          merged = col_max[win_col];
        end
        col_max[win_col] = merged;
        if (row_in_win == ws - 1) begin
          emits     = 1'b1;
          res.value = merged;
          res.last  = (win_col == nwin - 1) && (win_row == nwin - 1);
        end
      end
      col_in_win++;
      if (col_in_win == ws) begin
        col_in_win = 0;
        win_col++;
        if (win_col == nwin) begin
          win_col = 0;
          row_in_win++;
          if (row_in_win == ws) begin
            row_in_win = 0;
            win_row++;
            if (win_row == nwin) begin
              win_row = 0;
            end
          end
        end
      end
    end
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return pix_t'($signed($urandom_range(0, 7)) - 4);
      default: return pix_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic offer_pixel(input pix_t px, input bit use_typed, input pool_result_t typed);
    bit           emits;
    pool_result_t res;
    in_valid       <= 1'b1;
    in_pixel_value <= px;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_pool(px, emits, res);
    if (use_typed) begin
      emits = 1'b1;
      res   = typed;
    end
    if (emits) pooled_q.insert(pooled_q.size(), res);
    @(negedge clk);
  endtask

  // registers change only once the block has drained
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pooled_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    apply_cfg(idx, data);
  endtask

  task automatic pool_stream(input logic [CFG_DATA_W-1:0] ws_data,
                             input logic [CFG_DATA_W-1:0] ms_data,
                             input int n, input bit gapless, input bit press);
    int gap;
    write_cfg(REG_WINDOW_SIZE, ws_data);
    write_cfg(REG_MAP_SIZE, ms_data);
    if ($urandom_range(0, 5) == 0) begin
      write_cfg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                CFG_DATA_W'($urandom));
    end
    if (press) hold_req = 1'b1;
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = gapless ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      offer_pixel(rand_pixel(), 1'b0, NO_RES);
      random_items++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: stall pattern changes mode now and then
  initial begin
    int mode;
    int mode_left;
    int tick;
    out_stall = 1'b0;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= $urandom_range(0, 1);
          default: out_stall <= tick[1];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pooled_q.size() == 0) begin
        report_mismatch($sformatf("beat with nothing expected: value %0d last %b err %b",
                                  out_pooled_value, out_plane_last, out_config_error));
      end else begin
        got_want = pooled_q.pop_front();
        if (out_pooled_value !== got_want.value)
          report_mismatch($sformatf("pooled_value %0d, want %0d",
                                    out_pooled_value, got_want.value));
        if (out_plane_last !== got_want.last)
          report_mismatch($sformatf("plane_last %b, want %b", out_plane_last, got_want.last));
        if (out_config_error !== got_want.err)
          report_mismatch($sformatf("config_error %b, want %b",
                                    out_config_error, got_want.err));
      end
    end
  end

  // ends the run when no beat moves for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_MAX) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int ws;
    int ms;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel_value = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    hold_req       = 1'b0;
    mismatch_count = 0;
    random_items   = 0;
    burst_left     = 0;
    pool_ws        = WS_RESET;
    pool_ms        = MS_RESET;
    clear_position();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_cfg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        offer_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // back-pressure first, then the corners of the register ranges
    pool_stream(11'd1, 11'd4, 150, 1'b1, 1'b1);
    pool_stream(11'd16, 11'd16, 256, 1'b0, 1'b0);
    pool_stream(11'd1, 11'd1024, 150, 1'b0, 1'b0);
    pool_stream(11'd16, 11'd1024, 60, 1'b0, 1'b0);

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 4))
            0: begin ws = 0; ms = $urandom_range(1, 64); end
            1: begin ws = $urandom_range(17, 31); ms = $urandom_range(0, 2047); end
            2: begin ws = $urandom_range(1, 16); ms = 0; end
            3: begin ws = $urandom_range(1, 16); ms = $urandom_range(1025, 2047); end
            default: begin
              ws = $urandom_range(2, 16);
              ms = ws * $urandom_range(1, 8) + $urandom_range(1, ws - 1);
            end
          endcase
          pool_stream(CFG_DATA_W'(ws), CFG_DATA_W'(ms), $urandom_range(4, 12), 1'b0, 1'b0);
        end
        1: begin
          ws = $urandom_range(1, 4);
          ms = ws * $urandom_range(1, 6);
          pool_stream(CFG_DATA_W'(ws), CFG_DATA_W'(ms), $urandom_range(1, 30), 1'b0, 1'b0);
        end
        default: begin
          ws = $urandom_range(1, 4);
          ms = ws * $urandom_range(1, 6);
          // upper data bits beyond the window size field are dropped
          if ($urandom_range(0, 3) == 0) ws = ws | ($urandom_range(1, 63) << WS_W);
          pool_stream(CFG_DATA_W'(ws), CFG_DATA_W'(ms),
                      ms * ms * $urandom_range(1, 3) < 300 ?
                        ms * ms * $urandom_range(1, 3) : 300,
                      $urandom_range(0, 2) == 0, 1'b0);
        end
      endcase
    end

    in_valid <= 1'b0;
    while (pooled_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mps_pkg.sv
sv/mps_cfg.sv
sv/mps_front.sv
sv/mps_fifo.sv
sv/mps_back.sv
sv/max_pool_2d_stream.sv
tb/max_pool_2d_stream_tb.sv
